### src/box_blur_window_average_defines.svh
// Assertion macros shared by the box blur window average block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BOX_BLUR_WINDOW_AVERAGE_DEFINES_SVH
`define BOX_BLUR_WINDOW_AVERAGE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BBW_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define BBW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/bbw_pkg.sv
// Shared types and constants for the box blur window average block.
// No dependencies; imported by the controller, datapath and top level.
package bbw_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 12;

  localparam int POS_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int COORD_W  = 9;
  localparam int DIM_W    = 9;
  localparam int RAD_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PIXEL_W  = 3 * CHAN_W;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 9'd256;
  localparam logic [RAD_W-1:0] RESET_RADIUS = 4'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_write;
    logic query_start;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic in_inside;
    logic scan_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### src/bbw_ctrl.sv
// Controller state machine for the box blur window average block.
// Depends on bbw_pkg; drives the datapath through cmd_t and reads status_t.
module bbw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbw_pkg::status_t  status,
  output bbw_pkg::cmd_t     cmd
);
  import bbw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.in_query) begin
          state_next = status.in_inside ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_write  = in_valid && !status.in_query;
        cmd.query_start = in_valid && status.in_query;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd.div_init = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = !status.div_done;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### src/bbw_datapath.sv
// Datapath: frame store, window scan counters, channel sums, dividers, result register.
// Depends on bbw_pkg; sequenced by bbw_ctrl through cmd_t and status_t.
module bbw_datapath #(
  parameter int MAX_WIDTH  = bbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bbw_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_op,
  input  logic [bbw_pkg::POS_W-1:0]        in_x,
  input  logic [bbw_pkg::POS_W-1:0]        in_y,
  input  logic [bbw_pkg::PIXEL_W-1:0]      in_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bbw_pkg::PIXEL_W-1:0]      out_pixel,
  output logic                             out_error,
  input  bbw_pkg::cmd_t                    cmd,
  output bbw_pkg::status_t                 status
);
  import bbw_pkg::*;

  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EFF_RAD  = (MAX_RADIUS < 15) ? MAX_RADIUS : 15;
  localparam int AREA_MAX = (2 * EFF_RAD + 1) * (2 * EFF_RAD + 1);
  localparam int AREA_W   = $clog2(AREA_MAX + 1);
  localparam int SUM_W    = $clog2(AREA_MAX * 255 + 1);
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [RAD_W-1:0]   blur_radius;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [RAD_W-1:0]   r_eff;
  logic [4:0]         side;
  logic [9:0]         area_full;
  logic [AREA_W-1:0]  area;

  logic [COORD_W-1:0] xc;
  logic [COORD_W-1:0] yc;
  logic [COORD_W-1:0] rc;
  logic [COORD_W-1:0] x_sum;
  logic [COORD_W-1:0] y_sum;

  logic [COORD_W-1:0] x_lo;
  logic [COORD_W-1:0] x_hi;
  logic [COORD_W-1:0] y_hi;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               query_err;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]  mem_addr;
  logic [PIXEL_W-1:0] rd_data;
  logic               rd_pending;
  logic               mem_we;

  logic [SUM_W-1:0]   sum     [3];
  logic [SUM_W-1:0]   sum_acc [3];
  logic [SUM_W-1:0]   quo     [3];
  logic [AREA_W-1:0]  rem     [3];
  logic [SUM_W-1:0]   quo_next [3];
  logic [AREA_W-1:0]  rem_next [3];
  logic [DCNT_W-1:0]  div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      blur_radius  <= RESET_RADIUS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_BLUR_RADIUS:  blur_radius  <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_eff = (32'(frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width;
    h_eff = (32'(frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height;
    r_eff = (32'(blur_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : blur_radius;
    side      = {r_eff, 1'b1};
    area_full = 10'(side) * 10'(side);
    area      = AREA_W'(area_full);
    xc    = COORD_W'(in_x);
    yc    = COORD_W'(in_y);
    rc    = COORD_W'(r_eff);
    x_sum = xc + rc;
    y_sum = yc + rc;
  end

  assign status.in_query  = (in_op == OP_QUERY);
  assign status.in_inside = (xc < w_eff) && (yc < h_eff);
  assign status.scan_last = (cur_x == x_hi) && (cur_y == y_hi);
  assign status.div_done  = (div_cnt == DCNT_W'(SUM_W));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      query_err <= !status.in_inside;
      x_lo  <= (xc >= rc) ? xc - rc : '0;
      cur_x <= (xc >= rc) ? xc - rc : '0;
      cur_y <= (yc >= rc) ? yc - rc : '0;
      x_hi  <= (x_sum > w_eff - 1'b1) ? w_eff - 1'b1 : x_sum;
      y_hi  <= (y_sum > h_eff - 1'b1) ? h_eff - 1'b1 : y_sum;
    end else if (cmd.scan_step) begin
      if (cur_x == x_hi) begin
        cur_x <= x_lo;
        cur_y <= cur_y + 1'b1;
      end else begin
        cur_x <= cur_x + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = cmd.load_write && status.in_inside;
    if (cmd.scan_step) begin
      mem_addr = ADDR_W'(32'(cur_y) * MAX_WIDTH + 32'(cur_x));
    end else begin
      mem_addr = ADDR_W'(32'(in_y) * MAX_WIDTH + 32'(in_x));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_pixel;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.scan_step;
    end
  end

  always_comb begin
    logic [AREA_W:0] shifted;
    logic [AREA_W:0] trial;
    for (int i = 0; i < 3; i++) begin
      sum_acc[i] = sum[i] + (rd_pending ? SUM_W'(rd_data[CHAN_W*(2-i) +: CHAN_W]) : '0);
      shifted = {rem[i], quo[i][SUM_W-1]};
      trial   = shifted - {1'b0, area};
      if (!trial[AREA_W]) begin
        rem_next[i] = trial[AREA_W-1:0];
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[AREA_W-1:0];
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.query_start) begin
        sum[i] <= '0;
      end else begin
        sum[i] <= sum_acc[i];
      end
      if (cmd.div_init) begin
        quo[i] <= sum_acc[i];
        rem[i] <= '0;
      end else if (cmd.div_step) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
      end
    end
    if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_error <= query_err;
      if (query_err) begin
        out_pixel <= '0;
      end else begin
        out_pixel <= {quo[2][CHAN_W-1:0], quo[1][CHAN_W-1:0], quo[0][CHAN_W-1:0]};
      end
    end
  end

endmodule

### src/box_blur_window_average.sv
// Top level of the box blur window average block.
// Depends on bbw_pkg, bbw_ctrl, bbw_datapath and box_blur_window_average_defines.svh.
//
// Usage:
//   s_axis carries one transaction per load or query. tuser[0] selects the
//   operation (0 load, 1 query); tdata holds position and colour.
//   A load writes the frame store in the accepting cycle and is ready for the
//   next transaction in the following cycle; loads outside the frame are dropped.
//   A query reads every in-frame pixel of its window, one stored pixel per
//   cycle, N pixels in all, where N is the clipped window size (up to 625
//   at radius 12), then runs the bit-serial dividers over the channel sums
//   of width SUM_W (18 at radius 12). Out-of-frame queries skip the scan
//   and return zeros with the error flag set.
//   m_axis carries one result per query from an output register; the next
//   transaction is accepted while a result waits. A stalled receiver holds
//   the result and the block waits only when a second result is ready.
//   cfg takes a register write in any cycle; write only while idle.
//   Reset (rst, synchronous) restores 256 x 256 and radius 12 and empties the
//   pipeline; the frame store keeps undefined contents until loaded.
module box_blur_window_average #(
  parameter int MAX_WIDTH  = bbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bbw_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // x_pos[7:0], y_pos[15:8], red_in[23:16], green_in[31:24], blue_in[39:32]
  input  logic [39:0]                    s_axis_tdata,
  // operation[0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0]                    m_axis_tdata,
  // query_error[0]
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbw_pkg::*;

  `include "box_blur_window_average_defines.svh"

  cmd_t               cmd;
  status_t            status;
  logic [PIXEL_W-1:0] in_pixel;
  logic [PIXEL_W-1:0] out_pixel;

  assign cfg_ready = 1'b1;
  assign in_pixel  = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};

  bbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bbw_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser[0]),
    .in_x      (s_axis_tdata[7:0]),
    .in_y      (s_axis_tdata[15:8]),
    .in_pixel  (in_pixel),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (out_pixel),
    .out_error (m_axis_tuser[0]),
    .cmd       (cmd),
    .status    (status)
  );

  assign m_axis_tdata = out_pixel;

  `BBW_ASSERT_IMPLY(a_error_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata == 24'd0, "error result carries non-zero colour")
  `BBW_ASSERT_IMPLY(a_scan_blocks_input, clk, rst, cmd.scan_step, !s_axis_tready,
    "input accepted during window scan")
  `BBW_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.out_load,
    !m_axis_tvalid || m_axis_tready, "pending result overwritten")
  `BBW_ASSERT_NEXT(a_query_busy, clk, rst,
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready,
    "input ready straight after a query transaction")

endmodule
